// ===== rtl/core/uart_register_block_with_fifos_top_defines.svh =====
`ifndef UART_REGISTER_BLOCK_WITH_FIFOS_TOP_DEFINES_SVH
`define UART_REGISTER_BLOCK_WITH_FIFOS_TOP_DEFINES_SVH

// Concurrent assertion on a given clock, disabled while reset is low.
`define URBF_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same on the block clock and reset.
`define URBF_ASSERT(lbl, prop, msg) \
    `URBF_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)

`endif

// ===== rtl/core/urbf_pkg.sv =====
package urbf_pkg;

    localparam int DEFAULT_FIFO_DEPTH = 16;

    localparam logic [11:0] OFS_DATA  = 12'h000;
    localparam logic [11:0] OFS_FLAGS = 12'h018;
    localparam logic [11:0] OFS_IDIV  = 12'h024;
    localparam logic [11:0] OFS_FDIV  = 12'h028;
    localparam logic [11:0] OFS_LCTL  = 12'h02c;
    localparam logic [11:0] OFS_CTL   = 12'h030;
    localparam logic [11:0] OFS_MASK  = 12'h038;
    localparam logic [11:0] OFS_RAW   = 12'h03c;
    localparam logic [11:0] OFS_MSTAT = 12'h040;
    localparam logic [11:0] OFS_CLEAR = 12'h044;

    localparam int INT_RX  = 4;
    localparam int INT_TX  = 5;
    localparam int INT_OVR = 10;
    localparam int LCTL_FEN = 4;
    localparam int CTL_EN  = 0;
    localparam int CTL_TXE = 8;
    localparam int CTL_RXE = 9;

    localparam logic [15:0] CTL_RESET = 16'h0300;

    typedef enum logic [1:0] {
        ACT_READ,
        ACT_WRITE,
        ACT_RX_BYTE,
        ACT_TX_READY
    } t_action;

    typedef struct packed {
        logic [1:0]  action;
        logic [11:0] reg_offset;
        logic [15:0] write_data;
        logic [7:0]  line_byte;
    } t_item;

    typedef struct packed {
        logic [15:0] rd_value;
        logic        use_rx;
        logic        tx_valid;
        logic        irq;
    } t_stage;

endpackage

// ===== rtl/core/urbf_if.sv =====
interface urbf_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [11:0] reg_offset;
    logic [15:0] write_data;
    logic [7:0]  line_byte;

    modport source (output valid, action, reg_offset, write_data, line_byte, input ready);
    modport sink (input valid, action, reg_offset, write_data, line_byte, output ready);
endinterface

interface urbf_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] read_data;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        irq;

    modport source (output valid, read_data, tx_valid, tx_byte, irq, input ready);
    modport sink (input valid, read_data, tx_valid, tx_byte, irq, output ready);
endinterface

// ===== rtl/core/urbf_ram.sv =====
module urbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ===== rtl/core/urbf_ctrl.sv =====
module urbf_ctrl #(
    parameter int FIFO_DEPTH = urbf_pkg::DEFAULT_FIFO_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  urbf_pkg::t_item               i_item,
    output logic                          o_rx_wr_en,
    output logic [$clog2(FIFO_DEPTH)-1:0] o_rx_wr_addr,
    output logic                          o_rx_rd_en,
    output logic [$clog2(FIFO_DEPTH)-1:0] o_rx_rd_addr,
    output logic                          o_tx_wr_en,
    output logic [$clog2(FIFO_DEPTH)-1:0] o_tx_wr_addr,
    output logic                          o_tx_rd_en,
    output logic [$clog2(FIFO_DEPTH)-1:0] o_tx_rd_addr,
    output urbf_pkg::t_stage              o_stage
);
    import urbf_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    logic [CW-1:0] r_rx_count, n_rx_count, r_tx_count, n_tx_count;
    logic [AW-1:0] r_rx_head, n_rx_head, r_tx_head, n_tx_head;
    logic [15:0]   r_idiv, n_idiv, r_ctl, n_ctl;
    logic [5:0]    r_fdiv, n_fdiv;
    logic [7:0]    r_lctl, n_lctl;
    logic [10:0]   r_mask, n_mask, r_raw, n_raw;

    logic [CW-1:0] eff_depth, half_depth;
    logic          fifo_on;
    t_action       act;

    function automatic logic [AW-1:0] head_inc(input logic [AW-1:0] h);
        logic [AW-1:0] res;
        res = (h == AW'(FIFO_DEPTH - 1)) ? '0 : h + AW'(1);
        return res;
    endfunction

    function automatic logic [AW-1:0] tail_of(input logic [AW-1:0] h, input logic [CW-1:0] c);
        logic [CW:0] sum;
        sum = (CW+1)'(h) + (CW+1)'(c);
        if (sum >= (CW+1)'(FIFO_DEPTH)) begin
            sum = sum - (CW+1)'(FIFO_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    always_comb begin
        fifo_on    = r_ctl[CTL_EN];
        eff_depth  = r_lctl[LCTL_FEN] ? CW'(FIFO_DEPTH) : CW'(1);
        half_depth = r_lctl[LCTL_FEN] ? CW'(FIFO_DEPTH / 2) : '0;
        act        = t_action'(i_item.action);

        n_rx_count = r_rx_count;
        n_rx_head  = r_rx_head;
        n_tx_count = r_tx_count;
        n_tx_head  = r_tx_head;
        n_idiv     = r_idiv;
        n_fdiv     = r_fdiv;
        n_lctl     = r_lctl;
        n_ctl      = r_ctl;
        n_mask     = r_mask;
        n_raw      = r_raw;

        o_rx_wr_en   = 1'b0;
        o_rx_wr_addr = tail_of(r_rx_head, r_rx_count);
        o_rx_rd_en   = 1'b0;
        o_rx_rd_addr = r_rx_head;
        o_tx_wr_en   = 1'b0;
        o_tx_wr_addr = tail_of(r_tx_head, r_tx_count);
        o_tx_rd_en   = 1'b0;
        o_tx_rd_addr = r_tx_head;

        o_stage = '0;

        unique case (act)
            ACT_READ: begin
                unique case (i_item.reg_offset)
                    OFS_DATA: begin
                        if (r_rx_count != '0) begin
                            o_rx_rd_en     = i_accept;
                            o_stage.use_rx = 1'b1;
                            n_rx_head      = head_inc(r_rx_head);
                            n_rx_count     = r_rx_count - CW'(1);
                            if (n_rx_count == '0) begin
                                n_raw[INT_RX] = 1'b0;
                            end
                        end
                    end
                    OFS_FLAGS: begin
                        o_stage.rd_value[4] = (r_rx_count == '0);
                        o_stage.rd_value[5] = (r_tx_count >= eff_depth);
                        o_stage.rd_value[6] = (r_rx_count >= eff_depth);
                        o_stage.rd_value[7] = (r_tx_count == '0);
                    end
                    OFS_IDIV:  o_stage.rd_value = r_idiv;
                    OFS_FDIV:  o_stage.rd_value = 16'(r_fdiv);
                    OFS_LCTL:  o_stage.rd_value = 16'(r_lctl);
                    OFS_CTL:   o_stage.rd_value = r_ctl;
                    OFS_MASK:  o_stage.rd_value = 16'(r_mask);
                    OFS_RAW:   o_stage.rd_value = 16'(r_raw);
                    OFS_MSTAT: o_stage.rd_value = 16'(r_raw & r_mask);
                    default: begin
                    end
                endcase
            end
            ACT_WRITE: begin
                unique case (i_item.reg_offset)
                    OFS_DATA: begin
                        if (r_tx_count < eff_depth) begin
                            o_tx_wr_en = i_accept;
                            n_tx_count = r_tx_count + CW'(1);
                            if (n_tx_count > half_depth) begin
                                n_raw[INT_TX] = 1'b0;
                            end
                        end
                    end
                    OFS_IDIV:  n_idiv = i_item.write_data;
                    OFS_FDIV:  n_fdiv = i_item.write_data[5:0];
                    OFS_LCTL:  n_lctl = i_item.write_data[7:0];
                    OFS_CTL:   n_ctl  = i_item.write_data;
                    OFS_MASK:  n_mask = i_item.write_data[10:0];
                    OFS_CLEAR: n_raw  = r_raw & ~i_item.write_data[10:0];
                    default: begin
                    end
                endcase
            end
            ACT_RX_BYTE: begin
                if (fifo_on && r_ctl[CTL_RXE]) begin
                    if (r_rx_count < eff_depth) begin
                        o_rx_wr_en    = i_accept;
                        n_rx_count    = r_rx_count + CW'(1);
                        n_raw[INT_RX] = 1'b1;
                    end else begin
                        n_raw[INT_OVR] = 1'b1;
                    end
                end
            end
            ACT_TX_READY: begin
                if (fifo_on && r_ctl[CTL_TXE] && r_tx_count != '0) begin
                    o_tx_rd_en       = i_accept;
                    o_stage.tx_valid = 1'b1;
                    n_tx_head        = head_inc(r_tx_head);
                    n_tx_count       = r_tx_count - CW'(1);
                    if (n_tx_count <= half_depth) begin
                        n_raw[INT_TX] = 1'b1;
                    end
                end
            end
        endcase

        o_stage.irq = |(n_raw & n_mask);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_count <= '0;
            r_rx_head  <= '0;
            r_tx_count <= '0;
            r_tx_head  <= '0;
            r_idiv     <= '0;
            r_fdiv     <= '0;
            r_lctl     <= '0;
            r_ctl      <= CTL_RESET;
            r_mask     <= '0;
            r_raw      <= '0;
        end else if (i_accept) begin
            r_rx_count <= n_rx_count;
            r_rx_head  <= n_rx_head;
            r_tx_count <= n_tx_count;
            r_tx_head  <= n_tx_head;
            r_idiv     <= n_idiv;
            r_fdiv     <= n_fdiv;
            r_lctl     <= n_lctl;
            r_ctl      <= n_ctl;
            r_mask     <= n_mask;
            r_raw      <= n_raw;
        end
    end
endmodule

// ===== rtl/core/urbf_outq.sv =====
module urbf_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  urbf_pkg::t_stage  i_stage,
    input  logic [7:0]        i_rx_q,
    input  logic [7:0]        i_tx_q,
    output logic              o_ready,
    urbf_out_if.source        o_out
);
    import urbf_pkg::*;

    logic        r_s1_valid, n_s1_valid;
    t_stage      r_s1;
    logic        r_out_valid, n_out_valid;
    logic [15:0] r_read_data;
    logic        r_tx_valid;
    logic [7:0]  r_tx_byte;
    logic        r_irq;
    logic        adv;

    always_comb begin
        adv         = r_s1_valid && (!r_out_valid || o_out.ready);
        o_ready     = !r_s1_valid || adv;
        n_s1_valid  = i_accept || (r_s1_valid && !adv);
        n_out_valid = adv || (r_out_valid && !o_out.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1 <= i_stage;
        end
        if (adv) begin
            r_read_data <= r_s1.use_rx ? {8'h00, i_rx_q} : r_s1.rd_value;
            r_tx_valid  <= r_s1.tx_valid;
            r_tx_byte   <= r_s1.tx_valid ? i_tx_q : 8'h00;
            r_irq       <= r_s1.irq;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.read_data = r_read_data;
    assign o_out.tx_valid  = r_tx_valid;
    assign o_out.tx_byte   = r_tx_byte;
    assign o_out.irq       = r_irq;
endmodule

// ===== rtl/core/uart_register_block_with_fifos_top.sv =====
// UART register block with receive and transmit FIFOs.
// The input channel carries one event per transfer: a bus read, a bus write,
// a byte arriving from the receive line, or the transmit line asking for its
// next byte. The output channel returns exactly one result per event: the
// read data, the byte sent to the line with its valid bit, and the interrupt
// line as it stands after the event.
// An event is taken every cycle while results keep draining. A result
// passes through the registered read of the FIFO memory, then through the
// output register.
// Two events can be in flight; when the receiver stalls, the output register
// holds its result, the second event waits in the memory read stage and the
// input channel drops ready until the output moves again.
// Both FIFOs live in single-port-write, registered-read memories of
// FIFO_DEPTH bytes; only the pointers and counts are cleared.
// Synchronous reset clears the pointers, counts, registers and pipeline
// valid bits; the control register comes up with receive and transmit
// enabled and the UART off. Events are taken as soon as reset ends.
module uart_register_block_with_fifos_top #(
    parameter int FIFO_DEPTH = urbf_pkg::DEFAULT_FIFO_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    urbf_in_if.sink    i_in,
    urbf_out_if.source o_out
);
    import urbf_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);

    logic          accept, ready;
    t_item         item;
    t_stage        stage;
    logic          rx_wr_en, rx_rd_en, tx_wr_en, tx_rd_en;
    logic [AW-1:0] rx_wr_addr, rx_rd_addr, tx_wr_addr, tx_rd_addr;
    logic [7:0]    rx_q, tx_q;

    assign i_in.ready = ready;
    assign accept     = i_in.valid && ready;

    always_comb begin
        item.action     = i_in.action;
        item.reg_offset = i_in.reg_offset;
        item.write_data = i_in.write_data;
        item.line_byte  = i_in.line_byte;
    end

    urbf_ctrl #(
        .FIFO_DEPTH(FIFO_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (item),
        .o_rx_wr_en  (rx_wr_en),
        .o_rx_wr_addr(rx_wr_addr),
        .o_rx_rd_en  (rx_rd_en),
        .o_rx_rd_addr(rx_rd_addr),
        .o_tx_wr_en  (tx_wr_en),
        .o_tx_wr_addr(tx_wr_addr),
        .o_tx_rd_en  (tx_rd_en),
        .o_tx_rd_addr(tx_rd_addr),
        .o_stage     (stage)
    );

    urbf_ram #(
        .WIDTH(8),
        .DEPTH(FIFO_DEPTH)
    ) u_rx_ram (
        .i_clk    (i_clk),
        .i_wr_en  (rx_wr_en),
        .i_wr_addr(rx_wr_addr),
        .i_wr_data(item.line_byte),
        .i_rd_en  (rx_rd_en),
        .i_rd_addr(rx_rd_addr),
        .o_rd_data(rx_q)
    );

    urbf_ram #(
        .WIDTH(8),
        .DEPTH(FIFO_DEPTH)
    ) u_tx_ram (
        .i_clk    (i_clk),
        .i_wr_en  (tx_wr_en),
        .i_wr_addr(tx_wr_addr),
        .i_wr_data(item.write_data[7:0]),
        .i_rd_en  (tx_rd_en),
        .i_rd_addr(tx_rd_addr),
        .o_rd_data(tx_q)
    );

    urbf_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_stage (stage),
        .i_rx_q  (rx_q),
        .i_tx_q  (tx_q),
        .o_ready (ready),
        .o_out   (o_out)
    );
endmodule

// ===== rtl/core/urbf_checker.sv =====
`include "uart_register_block_with_fifos_top_defines.svh"

module urbf_prop_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_read_data,
    input logic        i_tx_valid,
    input logic [7:0]  i_tx_byte
);
    logic [2:0]  r_pend, n_pend;
    logic        in_xfer, out_xfer;
    logic        out_stall, quiet_tx;
    logic [24:0] payload;

    always_comb begin
        in_xfer   = i_in_valid && i_in_ready;
        out_xfer  = i_out_valid && i_out_ready;
        n_pend    = r_pend + 3'(in_xfer) - 3'(out_xfer);
        out_stall = i_out_valid && !i_out_ready;
        quiet_tx  = i_out_valid && !i_tx_valid;
        payload   = {i_read_data, i_tx_valid, i_tx_byte};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= n_pend;
        end
    end

    // A stalled result keeps its payload.
    `URBF_ASSERT(a_out_hold, out_stall |=> (i_out_valid && $stable(payload)), "stalled result changed")
    // Every result belongs to an event that was taken and not yet answered.
    `URBF_ASSERT(a_no_extra, i_out_valid |-> (r_pend != 3'd0), "result without a pending event")
    // At most the memory read stage and the output register hold events.
    `URBF_ASSERT(a_pend_max, r_pend <= 3'd2, "too many events in flight")
    // The line byte is zero in every valid result that sends no byte.
    `URBF_ASSERT(a_tx_zero, quiet_tx |-> (i_tx_byte == 8'h00), "tx byte set without tx valid")
endmodule

bind uart_register_block_with_fifos_top urbf_prop_checker u_urbf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in.valid),
    .i_in_ready (i_in.ready),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_read_data(o_out.read_data),
    .i_tx_valid (o_out.tx_valid),
    .i_tx_byte  (o_out.tx_byte)
);
